// ===== rtl/assert_macros.svh =====
// Assertion macros for the port-level checker of the matrix multiplier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at each rising clock edge, off while reset is asserted.
`define MM_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at each rising clock edge, reset included.
`define MM_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mm_pkg.sv =====
// Shared types and constants of the matrix multiplier.
package mm_pkg;

	localparam int DIM_W      = 4;
	localparam int ELEM_W     = 16;
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 35;
	localparam int SUM_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS_A     = 2'd0,
		CFG_INNER_SIZE = 2'd1,
		CFG_COLS_B     = 2'd2
	} cfg_idx_t;

	// Effective (saturated) dimensions of the current job.
	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] inner;
		logic [DIM_W-1:0] cols;
	} dims_t;

	typedef enum logic {
		BK_IDLE,
		BK_COMPUTE
	} back_state_t;

endpackage

// ===== rtl/mm_if.sv =====
// Stream and configuration interfaces of the matrix multiplier.
interface mm_elem_if;
	logic                              valid;
	logic                              ready;
	logic signed [mm_pkg::ELEM_W-1:0]  element;
	modport source (output valid, output element, input ready);
	modport sink   (input valid, input element, output ready);
endinterface

interface mm_prod_if;
	logic                              valid;
	logic                              ready;
	logic signed [mm_pkg::PROD_W-1:0]  product;
	logic                              last_product;
	modport source (output valid, output product, output last_product, input ready);
	modport sink   (input valid, input product, input last_product, output ready);
endinterface

interface mm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mm_pkg::CFG_IDX_W-1:0]      index;
	logic [mm_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/mm_front.sv =====
// Front end: configuration registers, load counter and element classification.
module mm_front #(
	parameter int MAX_DIM = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	mm_cfg_if.sink        cfg,
	mm_elem_if.sink       elements,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output logic [((MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)
		+ mm_pkg::ELEM_W + 2 - 1:0] cmd_data,
	output mm_pkg::dims_t dims
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LC_W   = $clog2(2 * DEPTH);

	logic [mm_pkg::DIM_W-1:0] rows_q, inner_q, cols_q;
	logic [LC_W-1:0]          load_count_q;
	logic [mm_pkg::SUM_W-1:0] na, nb, total, lc, lc_eff, offs;
	logic                     is_b, last, push, cfg_hit;

	function automatic logic [mm_pkg::DIM_W-1:0] eff_dim(input logic [mm_pkg::DIM_W-1:0] v);
		logic [mm_pkg::DIM_W-1:0] r;
		if (v == '0) begin
			r = mm_pkg::DIM_W'(1);
		end else if (v > mm_pkg::DIM_W'(MAX_DIM)) begin
			r = mm_pkg::DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign dims.rows  = eff_dim(rows_q);
	assign dims.inner = eff_dim(inner_q);
	assign dims.cols  = eff_dim(cols_q);

	assign na     = mm_pkg::SUM_W'(dims.rows) * mm_pkg::SUM_W'(dims.inner);
	assign nb     = mm_pkg::SUM_W'(dims.inner) * mm_pkg::SUM_W'(dims.cols);
	assign total  = na + nb;
	assign lc     = mm_pkg::SUM_W'(load_count_q);
	assign lc_eff = (lc >= total) ? '0 : lc;
	assign is_b   = (lc_eff >= na);
	assign offs   = is_b ? (lc_eff - na) : lc_eff;
	assign last   = ((lc_eff + mm_pkg::SUM_W'(1)) == total);

	assign cmd_data       = {is_b, last, offs[ADDR_W-1:0], elements.element};
	assign cmd_valid      = elements.valid;
	assign elements.ready = cmd_ready;
	assign cfg.ready      = 1'b1;
	assign push           = elements.valid && cmd_ready;

	assign cfg_hit = cfg.valid && cfg.ready
		&& ((cfg.index == mm_pkg::CFG_ROWS_A) || (cfg.index == mm_pkg::CFG_INNER_SIZE)
		|| (cfg.index == mm_pkg::CFG_COLS_B));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q       <= mm_pkg::DIM_RESET;
			inner_q      <= mm_pkg::DIM_RESET;
			cols_q       <= mm_pkg::DIM_RESET;
			load_count_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					mm_pkg::CFG_ROWS_A:     rows_q  <= cfg.data;
					mm_pkg::CFG_INNER_SIZE: inner_q <= cfg.data;
					mm_pkg::CFG_COLS_B:     cols_q  <= cfg.data;
					default: ;
				endcase
			end
			// A register write restarts the load.
			if (cfg_hit) begin
				load_count_q <= '0;
			end else if (push) begin
				load_count_q <= last ? '0 : LC_W'(lc_eff + mm_pkg::SUM_W'(1));
			end
		end
	end

endmodule

// ===== rtl/mm_queue.sv =====
// Small FIFO that decouples the front end from the compute back end.
module mm_queue #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/mm_back.sv =====
// Back end: writes element stores and runs the multiply-accumulate passes.
module mm_back #(
	parameter int MAX_DIM = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mm_pkg::dims_t dims,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  logic [((MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)
		+ mm_pkg::ELEM_W + 2 - 1:0] cmd_data,
	mm_prod_if.source     products
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	mm_pkg::back_state_t state_q, state_d;

	logic [mm_pkg::ELEM_W-1:0] cmd_elem;
	logic [ADDR_W-1:0]         cmd_addr;
	logic                      cmd_last, cmd_is_b;

	logic [IDX_W-1:0]  i_q, j_q, t_q;
	logic              end_i, end_j, end_t;
	logic              pop, adv, issue, a_we, b_we;
	logic [mm_pkg::SUM_W-1:0] a_lin, b_lin;
	logic [ADDR_W-1:0] a_raddr, b_raddr;
	logic [mm_pkg::ELEM_W-1:0] a_rd, b_rd;

	logic v_s1, first_s1, lastterm_s1, lastprod_s1;
	logic v_s2, first_s2, lastterm_s2, lastprod_s2;
	logic signed [mm_pkg::MUL_W-1:0]  prod_s2;
	logic signed [mm_pkg::PROD_W-1:0] acc_q, sum, product_q;
	logic out_valid_q, last_q;

	assign cmd_elem = cmd_data[mm_pkg::ELEM_W-1:0];
	assign cmd_addr = cmd_data[mm_pkg::ELEM_W +: ADDR_W];
	assign cmd_last = cmd_data[mm_pkg::ELEM_W + ADDR_W];
	assign cmd_is_b = cmd_data[mm_pkg::ELEM_W + ADDR_W + 1];

	// The whole compute pipeline moves only when the output register can take a value.
	assign adv   = !out_valid_q || products.ready;
	assign pop   = cmd_valid && cmd_ready;
	assign end_t = (t_q == IDX_W'(dims.inner - mm_pkg::DIM_W'(1)));
	assign end_j = (j_q == IDX_W'(dims.cols - mm_pkg::DIM_W'(1)));
	assign end_i = (i_q == IDX_W'(dims.rows - mm_pkg::DIM_W'(1)));

	assign a_lin   = mm_pkg::SUM_W'(i_q) * mm_pkg::SUM_W'(dims.inner) + mm_pkg::SUM_W'(t_q);
	assign b_lin   = mm_pkg::SUM_W'(t_q) * mm_pkg::SUM_W'(dims.cols) + mm_pkg::SUM_W'(j_q);
	assign a_raddr = a_lin[ADDR_W-1:0];
	assign b_raddr = b_lin[ADDR_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mm_pkg::BK_IDLE: begin
				if (pop && cmd_last) begin
					state_d = mm_pkg::BK_COMPUTE;
				end
			end
			mm_pkg::BK_COMPUTE: begin
				if (adv && end_i && end_j && end_t) begin
					state_d = mm_pkg::BK_IDLE;
				end
			end
			default: state_d = mm_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == mm_pkg::BK_IDLE);
		issue     = (state_q == mm_pkg::BK_COMPUTE) && adv;
		a_we      = pop && !cmd_is_b;
		b_we      = pop && cmd_is_b;
	end

	mm_ram #(.WIDTH(mm_pkg::ELEM_W), .DEPTH(DEPTH)) u_a_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (cmd_addr),
		.wdata (cmd_elem),
		.re    (issue),
		.raddr (a_raddr),
		.rdata (a_rd)
	);

	mm_ram #(.WIDTH(mm_pkg::ELEM_W), .DEPTH(DEPTH)) u_b_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (cmd_addr),
		.wdata (cmd_elem),
		.re    (issue),
		.raddr (b_raddr),
		.rdata (b_rd)
	);

	assign sum = first_s2 ? mm_pkg::PROD_W'(prod_s2) : acc_q + mm_pkg::PROD_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mm_pkg::BK_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			t_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mm_pkg::BK_IDLE && pop && cmd_last) begin
				i_q <= '0;
				j_q <= '0;
				t_q <= '0;
			end else if (issue) begin
				if (end_t) begin
					t_q <= '0;
					if (end_j) begin
						j_q <= '0;
						i_q <= i_q + IDX_W'(1);
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end else begin
					t_q <= t_q + IDX_W'(1);
				end
			end
			if (adv) begin
				v_s1        <= issue;
				v_s2        <= v_s1;
				out_valid_q <= v_s2 && lastterm_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1    <= (t_q == '0);
			lastterm_s1 <= end_t;
			lastprod_s1 <= end_i && end_j && end_t;
			first_s2    <= first_s1;
			lastterm_s2 <= lastterm_s1;
			lastprod_s2 <= lastprod_s1;
			prod_s2     <= $signed(a_rd) * $signed(b_rd);
			if (v_s2) begin
				acc_q <= sum;
			end
			if (v_s2 && lastterm_s2) begin
				product_q <= sum;
				last_q    <= lastprod_s2;
			end
		end
	end

	assign products.valid        = out_valid_q;
	assign products.product      = product_q;
	assign products.last_product = last_q;

endmodule

// ===== rtl/matrix_multiply_core.sv =====
// Matrix multiplier: elements of A then B in, product matrix out, row-major.
// Each element is accepted while the queue has room; the back end writes it when it pops it, while idle.
// The last B element starts R*C*K multiply-accumulate terms, one per cycle unless the output stalls.
// Each product is summed from the store reads through the product register into the output register.
// Elements keep queueing during the pass until the queue is full, then the input stalls.
// Asynchronous active-low reset clears control state; the element stores hold no reset value.
module matrix_multiply_core #(
	parameter int MAX_DIM     = 8,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	mm_cfg_if.sink    cfg,
	mm_elem_if.sink   elements,
	mm_prod_if.source products
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMD_W  = ADDR_W + mm_pkg::ELEM_W + 2;

	mm_pkg::dims_t    dims;
	logic             f_valid, f_ready, b_valid, b_ready;
	logic [CMD_W-1:0] f_data, b_data;

	mm_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.elements  (elements),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd_data  (f_data),
		.dims      (dims)
	);

	mm_queue #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_data)
	);

	mm_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dims      (dims),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd_data  (b_data),
		.products  (products)
	);

endmodule

// ===== rtl/mm_checker.sv =====
// Port-level checker for the matrix multiplier, bound to the top level.
`include "assert_macros.svh"

module mm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [mm_pkg::PROD_W-1:0] out_product,
	input logic                             out_last
);

	// A stalled product transaction keeps its payload.
	`MM_ASSERT_RST(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_product) && $stable(out_last), "product changed while stalled")

	// A later job's terms cannot reach the output right behind the final product, so a bubble always follows it.
	`MM_ASSERT_RST(a_gap_after_last, clk, arst_n, out_valid && out_ready && out_last |=> !out_valid, "product right after the final one")

	// Reset holds the output channel empty.
	`MM_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid, "product valid during reset")

endmodule

bind matrix_multiply_core mm_checker u_mm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (products.valid),
	.out_ready   (products.ready),
	.out_product (products.product),
	.out_last    (products.last_product)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the matrix multiplier core.
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_DIM       = 8;
	localparam int IDLE_PCT      = 29;
	localparam int RANDOM_ITEMS  = 85;
	localparam int SETTLE_CYCLES = 32;
	localparam int LONG_HOLD     = 300;
	localparam int QUIET_LIMIT   = 4000;
	localparam logic [mm_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

	typedef struct {
		logic signed [mm_pkg::PROD_W-1:0] product;
		logic                             last_product;
	} prod_expect_t;

	logic clk = 1'b0;
	logic arst_n;

	mm_cfg_if  cfg_bus ();
	mm_elem_if elem_bus ();
	mm_prod_if prod_bus ();

	matrix_multiply_core #(
		.MAX_DIM(MAX_DIM)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.elements(elem_bus),
		.products(prod_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state, updated only from accepted transactions.
	logic [mm_pkg::DIM_W-1:0]         dim_reg [3];
	logic signed [mm_pkg::ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
	logic signed [mm_pkg::ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
	int                               loaded;
	prod_expect_t                     pending_products [$];

	// Stimulus side.
	logic signed [mm_pkg::ELEM_W-1:0] element_backlog [$];
	logic signed [mm_pkg::ELEM_W-1:0] batch [$];
	logic [mm_pkg::DIM_W-1:0]         cur_dim [3];
	logic                             elem_fire;
	logic                             calm;
	logic                             want_hold;
	logic                             hold_done;
	int                               hold_left;

	int elem_queued;
	int elem_accepted;
	int products_checked;
	int reg_writes;
	int errors;
	int quiet;

	function automatic int clamp_dim(logic [mm_pkg::DIM_W-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_DIM)
			return MAX_DIM;
		return int'(raw);
	endfunction

	task automatic absorb_element(input logic signed [mm_pkg::ELEM_W-1:0] v);
		int r, k, c, na, nb;
		longint acc;
		prod_expect_t e;
		r = clamp_dim(dim_reg[mm_pkg::CFG_ROWS_A]);
		k = clamp_dim(dim_reg[mm_pkg::CFG_INNER_SIZE]);
		c = clamp_dim(dim_reg[mm_pkg::CFG_COLS_B]);
		na = r * k;
		nb = k * c;
		if (loaded >= na + nb)
			loaded = 0;
		if (loaded < na)
			a_mem[loaded] = v;
		else
			b_mem[loaded - na] = v;
		loaded++;
		if (loaded == na + nb) begin
			loaded = 0;
			for (int i = 0; i < r; i++) begin
				for (int j = 0; j < c; j++) begin
					acc = 0;
					for (int t = 0; t < k; t++)
						acc += longint'(a_mem[i*k + t]) * longint'(b_mem[t*c + j]);
					e.product = acc[mm_pkg::PROD_W-1:0];
					e.last_product = (i == r - 1) && (j == c - 1);
					pending_products.push_back(e);
				end
			end
		end
	endtask

	// Everything accepted is observed at the rising edge.
	always @(posedge clk) begin
		prod_expect_t e;
		logic any_fire;
		any_fire = 1'b0;
		elem_fire <= (elem_bus.valid && elem_bus.ready) === 1'b1;
		if ((cfg_bus.valid && cfg_bus.ready) === 1'b1) begin
			any_fire = 1'b1;
			reg_writes++;
			if (cfg_bus.index != CFG_NO_REG) begin
				dim_reg[cfg_bus.index] = cfg_bus.data;
				loaded = 0;
			end
		end
		if ((elem_bus.valid && elem_bus.ready) === 1'b1) begin
			any_fire = 1'b1;
			elem_accepted++;
			absorb_element(elem_bus.element);
		end
		if ((prod_bus.valid && prod_bus.ready) === 1'b1) begin
			any_fire = 1'b1;
			if (pending_products.size() == 0) begin
				$display("%0t: unexpected product, expected none, got %0d last %0b",
					$time, prod_bus.product, prod_bus.last_product);
				errors++;
			end else begin
				e = pending_products.pop_front();
				if (prod_bus.product !== e.product) begin
					$display("%0t: product %0d expected %0d, got %0d",
						$time, products_checked, e.product, prod_bus.product);
					errors++;
				end
				if (prod_bus.last_product !== e.last_product) begin
					$display("%0t: product %0d last_product expected %0b, got %0b",
						$time, products_checked, e.last_product, prod_bus.last_product);
					errors++;
				end
			end
			products_checked++;
		end
		quiet = any_fire ? 0 : quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("matrix_multiply_core: mismatch");
			$finish;
		end
	end

	// Element driver: a transaction on offer stays until it is taken.
	always @(negedge clk) begin
		if (elem_fire === 1'b1)
			void'(element_backlog.pop_front());
		if (elem_bus.valid === 1'b1 && elem_fire !== 1'b1) begin
			elem_bus.valid <= 1'b1;
		end else if (element_backlog.size() != 0
				&& (calm || $urandom_range(99) >= IDLE_PCT)) begin
			elem_bus.valid <= 1'b1;
			elem_bus.element <= element_backlog[0];
		end else begin
			elem_bus.valid <= 1'b0;
		end
	end

	// Product receiver, with one long hold-off while the sender keeps going.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			prod_bus.ready <= 1'b0;
		end else if (want_hold && !hold_done && prod_bus.valid === 1'b1) begin
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
			prod_bus.ready <= 1'b0;
		end else begin
			prod_bus.ready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	task automatic settle();
		do
			@(negedge clk);
		while (elem_accepted != elem_queued || pending_products.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [mm_pkg::CFG_IDX_W-1:0] idx,
			input logic [mm_pkg::DIM_W-1:0] val);
		@(negedge clk);
		cfg_bus.valid = 1'b1;
		cfg_bus.index = idx;
		cfg_bus.data = val;
		do
			@(posedge clk);
		while (cfg_bus.ready !== 1'b1);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
		if (idx != CFG_NO_REG)
			cur_dim[idx] = val;
	endtask

	task automatic flush_batch();
		@(posedge clk);
		foreach (batch[i])
			element_backlog.push_back(batch[i]);
		elem_queued += batch.size();
		batch = {};
	endtask

	function automatic logic signed [mm_pkg::ELEM_W-1:0] rand_element();
		case ($urandom_range(19))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return mm_pkg::ELEM_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic int job_length();
		int r, k, c;
		r = clamp_dim(cur_dim[mm_pkg::CFG_ROWS_A]);
		k = clamp_dim(cur_dim[mm_pkg::CFG_INNER_SIZE]);
		c = clamp_dim(cur_dim[mm_pkg::CFG_COLS_B]);
		return r * k + k * c;
	endfunction

	// Mostly small sizes; now and then the largest or an out-of-range value.
	function automatic logic [mm_pkg::DIM_W-1:0] pick_dim();
		int sel;
		sel = $urandom_range(99);
		if (sel < 5)
			return 4'd0;
		if (sel < 10)
			return mm_pkg::DIM_W'($urandom_range(9, 15));
		if (sel < 15)
			return 4'd8;
		return mm_pkg::DIM_W'($urandom_range(1, 4));
	endfunction

	initial begin
		int target, phase, n_jobs, cut, written;
		arst_n = 1'b1;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = mm_pkg::CFG_ROWS_A;
		cfg_bus.data = '0;
		elem_bus.valid = 1'b0;
		elem_bus.element = '0;
		prod_bus.ready = 1'b0;
		elem_fire = 1'b0;
		calm = 1'b0;
		want_hold = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		loaded = 0;
		elem_queued = 0;
		elem_accepted = 0;
		products_checked = 0;
		reg_writes = 0;
		errors = 0;
		quiet = 0;
		for (int i = 0; i < 3; i++) begin
			dim_reg[i] = mm_pkg::DIM_RESET;
			cur_dim[i] = mm_pkg::DIM_RESET;
		end
		// The falling reset edge comes after every process is waiting on it.
		#1 arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Inner size stays at its reset value; a zero column count acts as one.
		// The most negative operand squared eight times gives the top of the product range.
		write_reg(mm_pkg::CFG_ROWS_A, 4'd1);
		write_reg(mm_pkg::CFG_COLS_B, 4'd0);
		repeat (16) batch.push_back(16'sh8000);
		flush_batch();
		settle();

		// A register write, even of the same value, throws away a partial load.
		// A write to the unused index must leave the load alone.
		write_reg(mm_pkg::CFG_INNER_SIZE, 4'd1);
		batch.push_back(16'sd7);
		flush_batch();
		settle();
		write_reg(mm_pkg::CFG_COLS_B, 4'd1);
		batch.push_back(16'sh7FFF);
		flush_batch();
		settle();
		write_reg(CFG_NO_REG, 4'd15);
		batch.push_back(16'sh8000);
		flush_batch();
		settle();

		// Rows saturate from fifteen to eight.
		write_reg(mm_pkg::CFG_ROWS_A, 4'd15);
		write_reg(mm_pkg::CFG_COLS_B, 4'd2);
		batch = {16'sh7FFF, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh8000, 16'sh5555,
			16'shAAAA, 16'sh0002, 16'shFFFF, 16'sh7FFF};
		flush_batch();
		settle();

		target = elem_queued + RANDOM_ITEMS;
		for (phase = 1; elem_queued < target; phase++) begin
			calm <= (phase >= 2);
			if (phase == 1) begin
				// Back-to-back jobs while the receiver stalls fill the block up.
				write_reg(mm_pkg::CFG_ROWS_A, 4'd4);
				write_reg(mm_pkg::CFG_INNER_SIZE, 4'd2);
				write_reg(mm_pkg::CFG_COLS_B, 4'd4);
				want_hold <= 1'b1;
				n_jobs = 4;
			end else begin
				written = 0;
				for (int idx = 0; idx < 3; idx++) begin
					if ($urandom_range(3) != 0) begin
						write_reg(idx[mm_pkg::CFG_IDX_W-1:0], pick_dim());
						written++;
					end
				end
				if (written == 0)
					write_reg(mm_pkg::CFG_ROWS_A, pick_dim());
				if ($urandom_range(4) == 0)
					write_reg(CFG_NO_REG, mm_pkg::DIM_W'($urandom_range(0, 15)));
				if ($urandom_range(5) == 0 && job_length() > 1) begin
					cut = $urandom_range(1, job_length() - 1);
					repeat (cut) batch.push_back(rand_element());
					flush_batch();
					settle();
					write_reg(mm_pkg::CFG_INNER_SIZE, pick_dim());
				end
				n_jobs = (job_length() > 40) ? 1 : $urandom_range(1, 3);
			end
			repeat (n_jobs) begin
				repeat (job_length()) batch.push_back(rand_element());
				flush_batch();
			end
			settle();
		end
		calm <= 1'b0;

		$display("Run covered %0d elements and %0d register writes over %0d random phases,",
			elem_accepted, reg_writes, phase - 1);
		$display("with %0d product elements checked, saturated sizes and aborted loads among them.",
			products_checked);
		if (errors == 0)
			$display("matrix_multiply_core: match");
		else
			$display("matrix_multiply_core: mismatch");
		$finish;
	end

endmodule
